/* hw/rtl/vertex_tuple_dedup_indexer_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the vertex tuple dedup indexer
// Same-cycle and next-cycle implications, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef VERTEX_TUPLE_DEDUP_INDEXER_MACROS_SVH
`define VERTEX_TUPLE_DEDUP_INDEXER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VTDI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VTDI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/vtdi_pkg.sv */
// ----------------------------------------------------------------------------
// vtdi_pkg
// Types and constants shared by the vertex tuple dedup indexer.
// ----------------------------------------------------------------------------
package vtdi_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int VIDX_W      = 8;
    localparam int WORD_W      = 32;
    localparam int POS_W       = 3 * WORD_W;
    localparam int ATTR_W      = 5 * WORD_W;

    typedef struct packed {
        logic              first_of_mesh;
        logic [WORD_W-1:0] pos_x;
        logic [WORD_W-1:0] pos_y;
        logic [WORD_W-1:0] pos_z;
        logic [WORD_W-1:0] nrm_x;
        logic [WORD_W-1:0] nrm_y;
        logic [WORD_W-1:0] nrm_z;
        logic [WORD_W-1:0] tex_u;
        logic [WORD_W-1:0] tex_v;
    } t_in;

    typedef struct packed {
        logic [VIDX_W-1:0] vertex_index;
        logic              is_new;
        logic              table_full;
    } t_out;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
    } t_mem_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // Low bits of a table index as the reported vertex index.
    function automatic logic [VIDX_W-1:0] to_vidx(input logic [IDX_W-1:0] idx);
        logic [IDX_W+VIDX_W-1:0] ext;
        ext = (IDX_W + VIDX_W)'(idx);
        return ext[VIDX_W-1:0];
    endfunction

endpackage

/* hw/rtl/vertex_tuple_dedup_indexer.sv */
// ----------------------------------------------------------------------------
// vertex_tuple_dedup_indexer
// Corner tuple deduplication with index assignment over a linear-scan table.
// ----------------------------------------------------------------------------
// One request carries a triangle corner: three position words, three normal
// words and two texture words, all raw 32-bit patterns, plus a first-of-mesh
// flag that empties the table before the corner is handled. The corner is
// compared bit for bit against the stored tuples from entry 0 up; the first
// match returns its index, otherwise the tuple is appended and its new index
// returned with is_new set. With no match and all TABLE_DEPTH entries in use,
// nothing is stored and table_full is returned with index 0. The scan
// time grows with the entry count and ends early on a match: the position
// and attribute stores each have one read port, and the scan reads one
// entry per cycle through a registered read. Only one request is in
// flight; the result sits in an output register, so the next request is
// taken while the previous result is still waiting for the downstream side.
// ----------------------------------------------------------------------------
module vertex_tuple_dedup_indexer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  vtdi_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output vtdi_pkg::t_out  o_out_data
);

    vtdi_pkg::t_mem_ctl              mem_ctl;
    logic [vtdi_pkg::POS_W-1:0]      pos_rdata;
    logic [vtdi_pkg::ATTR_W-1:0]     attr_rdata;
    logic [vtdi_pkg::POS_W-1:0]      wr_pos;
    logic [vtdi_pkg::ATTR_W-1:0]     wr_attr;
    logic                            res_valid;
    vtdi_pkg::t_out                  res;
    logic                            res_load;

    logic                            r_out_valid, n_out_valid;
    vtdi_pkg::t_out                  r_out_data, n_out_data;

    // Sequencer: owns the entry count and drives both stores.
    vtdi_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .o_in_stall   (o_in_stall),
        .i_pos_rdata  (pos_rdata),
        .i_attr_rdata (attr_rdata),
        .o_mem        (mem_ctl),
        .o_wr_pos     (wr_pos),
        .o_wr_attr    (wr_attr),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_taken  (res_load)
    );

    // Position words of each stored tuple.
    vtdi_ram #(
        .WIDTH (vtdi_pkg::POS_W),
        .DEPTH (vtdi_pkg::TABLE_DEPTH)
    ) u_pos_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_ctl.wr_en),
        .i_wr_addr (mem_ctl.wr_addr),
        .i_wr_data (wr_pos),
        .i_rd_en   (mem_ctl.rd_en),
        .i_rd_addr (mem_ctl.rd_addr),
        .o_rd_data (pos_rdata)
    );

    // Normal and texture words of each stored tuple.
    vtdi_ram #(
        .WIDTH (vtdi_pkg::ATTR_W),
        .DEPTH (vtdi_pkg::TABLE_DEPTH)
    ) u_attr_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_ctl.wr_en),
        .i_wr_addr (mem_ctl.wr_addr),
        .i_wr_data (wr_attr),
        .i_rd_en   (mem_ctl.rd_en),
        .i_rd_addr (mem_ctl.rd_addr),
        .o_rd_data (attr_rdata)
    );

    // Load the output register when it is empty or being drained this cycle;
    // hold it while the downstream side stalls.
    assign res_load = res_valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (res_load) begin
            n_out_valid = 1'b1;
            n_out_data  = res;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* hw/rtl/vtdi_ram.sv */
// ----------------------------------------------------------------------------
// vtdi_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module vtdi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                       i_clk,
    input  logic                                       i_wr_en,
    input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                           i_wr_data,
    input  logic                                       i_rd_en,
    input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                           o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/vtdi_ctrl.sv */
// ----------------------------------------------------------------------------
// vtdi_ctrl
// Scan sequencer: walks the stored tuples, compares, appends on a miss while an entry is free.
// ----------------------------------------------------------------------------
`include "vertex_tuple_dedup_indexer_macros.svh"

module vtdi_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  vtdi_pkg::t_in                 i_in_data,
    output logic                          o_in_stall,
    input  logic [vtdi_pkg::POS_W-1:0]    i_pos_rdata,
    input  logic [vtdi_pkg::ATTR_W-1:0]   i_attr_rdata,
    output vtdi_pkg::t_mem_ctl            o_mem,
    output logic [vtdi_pkg::POS_W-1:0]    o_wr_pos,
    output logic [vtdi_pkg::ATTR_W-1:0]   o_wr_attr,
    output logic                          o_res_valid,
    output vtdi_pkg::t_out                o_res,
    input  logic                          i_res_taken
);

    vtdi_pkg::t_state               r_state, n_state;
    logic [vtdi_pkg::CNT_W-1:0]     r_count, n_count;
    logic [vtdi_pkg::CNT_W-1:0]     r_limit, n_limit;
    logic [vtdi_pkg::CNT_W-1:0]     r_addr, n_addr;
    logic                           r_cmp_valid, n_cmp_valid;
    logic [vtdi_pkg::IDX_W-1:0]     r_cmp_addr, n_cmp_addr;
    vtdi_pkg::t_in                  r_tuple, n_tuple;
    vtdi_pkg::t_out                 r_res, n_res;

    logic accept;
    logic issue;
    logic hit;
    logic scan_end;
    logic miss;
    logic room;
    logic [vtdi_pkg::POS_W-1:0]  key_pos;
    logic [vtdi_pkg::ATTR_W-1:0] key_attr;

    assign key_pos  = {r_tuple.pos_x, r_tuple.pos_y, r_tuple.pos_z};
    assign key_attr = {r_tuple.nrm_x, r_tuple.nrm_y, r_tuple.nrm_z,
                       r_tuple.tex_u, r_tuple.tex_v};

    assign accept   = (r_state == vtdi_pkg::S_IDLE) && i_in_valid;
    assign issue    = (r_state == vtdi_pkg::S_SCAN) && (r_addr < r_limit);
    assign hit      = r_cmp_valid && (i_pos_rdata == key_pos) && (i_attr_rdata == key_attr);
    assign scan_end = (r_state == vtdi_pkg::S_SCAN) && (hit || (!r_cmp_valid && !issue));
    assign miss     = scan_end && !hit;
    assign room     = r_limit < vtdi_pkg::CNT_W'(vtdi_pkg::TABLE_DEPTH);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vtdi_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = vtdi_pkg::S_SCAN;
                end
            end
            vtdi_pkg::S_SCAN: begin
                if (scan_end) begin
                    n_state = vtdi_pkg::S_DONE;
                end
            end
            vtdi_pkg::S_DONE: begin
                if (i_res_taken) begin
                    n_state = vtdi_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = vtdi_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_in_stall    = (r_state != vtdi_pkg::S_IDLE);
        o_res_valid   = (r_state == vtdi_pkg::S_DONE);
        o_res         = r_res;
        o_mem.rd_en   = issue;
        o_mem.rd_addr = r_addr[vtdi_pkg::IDX_W-1:0];
        o_mem.wr_en   = miss && room;
        o_mem.wr_addr = r_limit[vtdi_pkg::IDX_W-1:0];
        o_wr_pos      = key_pos;
        o_wr_attr     = key_attr;
    end

    // Datapath next values
    always_comb begin
        n_count     = r_count;
        n_limit     = r_limit;
        n_addr      = r_addr;
        n_tuple     = r_tuple;
        n_res       = r_res;
        n_cmp_valid = issue && !hit;
        n_cmp_addr  = r_addr[vtdi_pkg::IDX_W-1:0];
        if (accept) begin
            n_tuple = i_in_data;
            n_addr  = '0;
            if (i_in_data.first_of_mesh) begin
                n_limit = '0;
                n_count = '0;
            end else begin
                n_limit = r_count;
            end
        end else if (issue) begin
            n_addr = r_addr + 1'b1;
        end
        priority if (hit) begin
            n_res.vertex_index = vtdi_pkg::to_vidx(r_cmp_addr);
            n_res.is_new       = 1'b0;
            n_res.table_full   = 1'b0;
        end else if (miss && room) begin
            n_res.vertex_index = vtdi_pkg::to_vidx(r_limit[vtdi_pkg::IDX_W-1:0]);
            n_res.is_new       = 1'b1;
            n_res.table_full   = 1'b0;
            n_count            = r_limit + 1'b1;
        end else if (miss) begin
            n_res.vertex_index = '0;
            n_res.is_new       = 1'b0;
            n_res.table_full   = 1'b1;
        end else begin
            n_res = r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vtdi_pkg::S_IDLE;
            r_count     <= '0;
            r_cmp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cmp_valid <= n_cmp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_limit    <= n_limit;
        r_addr     <= n_addr;
        r_cmp_addr <= n_cmp_addr;
        r_tuple    <= n_tuple;
        r_res      <= n_res;
    end

    `VTDI_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= vtdi_pkg::CNT_W'(vtdi_pkg::TABLE_DEPTH), "entry count above table depth")
    `VTDI_ASSERT_NEXT(a_append_count, i_clk, i_rst_n, o_mem.wr_en, r_count == vtdi_pkg::CNT_W'($past(r_limit) + 1'b1), "append did not advance entry count")
    `VTDI_ASSERT_NOW(a_full_count, i_clk, i_rst_n, (r_state == vtdi_pkg::S_DONE) && r_res.table_full, r_count == vtdi_pkg::CNT_W'(vtdi_pkg::TABLE_DEPTH), "table full reported with free entries")
    `VTDI_ASSERT_NOW(a_cmp_in_scan, i_clk, i_rst_n, r_cmp_valid, r_state == vtdi_pkg::S_SCAN, "compare pending outside scan")

endmodule

/* verif/tb_vertex_tuple_dedup_indexer.sv */
// ----------------------------------------------------------------------------
// tb_vertex_tuple_dedup_indexer
// Self-checking bench for the corner tuple dedup indexer. A queue of corner
// requests, filled at time zero, feeds a clocked driver. The driver predicts
// every accepted request against its own copy of the unique-corner table.
// A clocked monitor compares each result with the oldest prediction. Both
// sides idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_vertex_tuple_dedup_indexer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 5;
    localparam int CORNER_GOAL  = 1975;            // directed plus about 1950 random
    localparam int QUIET_LIMIT  = 4000;            // cycles with no handshake at all
    localparam int HOLD_CYCLES  = 500;             // one long receiver hold-off
    localparam int HOLD_AFTER   = 150;             // results seen before the hold-off
    localparam int TAIL_CYCLES  = vtdi_pkg::TABLE_DEPTH + 8; // a full scan plus margin
    localparam int IDLE_PCT     = 20;
    localparam int CALM_FROM    = 600;             // no idling on either side
    localparam int CALM_TO      = 1000;            // between these counts
    localparam int PRINT_LIMIT  = 40;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_stall;
    vtdi_pkg::t_in  in_data   = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    vtdi_pkg::t_out out_data;

    // Requests still to be offered and results still owed, both in order.
    vtdi_pkg::t_in  pending_corners[$];
    vtdi_pkg::t_out owed_results[$];

    // Predictor copy of the unique-corner table.
    logic [8*vtdi_pkg::WORD_W-1:0] known_corners[vtdi_pkg::TABLE_DEPTH];
    int                            known_count = 0;

    int corners_queued = 0;
    int requests_sent  = 0;
    int results_seen   = 0;
    int fail_count     = 0;
    int quiet_cycles   = 0;
    int hold_left      = 0;
    logic hold_done    = 1'b0;

    vertex_tuple_dedup_indexer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Prediction: clear on first-of-mesh, search from entry 0 with exact bit
    // compare, append on a miss, flag a full table when no entry is free.
    // ------------------------------------------------------------------------
    function automatic vtdi_pkg::t_out lookup_corner(input vtdi_pkg::t_in c);
        vtdi_pkg::t_out                r;
        logic [8*vtdi_pkg::WORD_W-1:0] key;
        key = {c.pos_x, c.pos_y, c.pos_z, c.nrm_x, c.nrm_y, c.nrm_z, c.tex_u, c.tex_v};
        r   = '0;
        if (c.first_of_mesh) begin
            known_count = 0;
        end
        for (int s = 0; s < known_count; s++) begin
            if (known_corners[s] == key) begin
                r.vertex_index = vtdi_pkg::VIDX_W'(s);
                return r;
            end
        end
        if (known_count < vtdi_pkg::TABLE_DEPTH) begin
            known_corners[known_count] = key;
            r.vertex_index = vtdi_pkg::VIDX_W'(known_count);
            r.is_new       = 1'b1;
            known_count++;
        end else begin
            r.table_full = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [8*vtdi_pkg::WORD_W-1:0] random_words();
        logic [8*vtdi_pkg::WORD_W-1:0] w;
        for (int k = 0; k < 8; k++) begin
            w[vtdi_pkg::WORD_W*k +: vtdi_pkg::WORD_W] = $urandom;
        end
        return w;
    endfunction

    // Pack the eight words, position x first, and append the request.
    task automatic queue_corner(input logic first,
                                input logic [8*vtdi_pkg::WORD_W-1:0] w);
        vtdi_pkg::t_in c;
        c.first_of_mesh = first;
        {c.pos_x, c.pos_y, c.pos_z, c.nrm_x, c.nrm_y, c.nrm_z, c.tex_u, c.tex_v} = w;
        pending_corners.push_back(c);
        corners_queued++;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fail_count < PRINT_LIMIT) begin
            $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        end
        fail_count++;
    endtask

    // ------------------------------------------------------------------------
    // Driver: predict each accepted request, then offer the next one unless
    // this cycle idles. Hold the payload while the block stalls.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                owed_results.push_back(lookup_corner(in_data));
                requests_sent <= requests_sent + 1;
            end
            if (!in_valid || !in_stall) begin
                if (pending_corners.size() != 0 &&
                    ((requests_sent >= CALM_FROM && requests_sent < CALM_TO) ||
                     $urandom_range(99) >= IDLE_PCT)) begin
                    in_data  <= pending_corners.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver stall: random idling, a calm stretch, and one long hold-off
    // that lets the block fill up and stall its own input.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end else if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_left <= HOLD_CYCLES - 1;
                hold_done <= 1'b1;
                out_stall <= 1'b1;
            end else if (results_seen >= CALM_FROM && results_seen < CALM_TO) begin
                out_stall <= 1'b0;
            end else begin
                out_stall <= ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compare every accepted result with the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        vtdi_pkg::t_out want;
        if (rst_n && out_valid && !out_stall) begin
            results_seen <= results_seen + 1;
            if (owed_results.size() == 0) begin
                report_mismatch("unexpected result, index",
                                int'(out_data.vertex_index), -1);
            end else begin
                want = owed_results.pop_front();
                if (out_data.vertex_index !== want.vertex_index) begin
                    report_mismatch("vertex_index", int'(out_data.vertex_index),
                                    int'(want.vertex_index));
                end
                if (out_data.is_new !== want.is_new) begin
                    report_mismatch("is_new", int'(out_data.is_new), int'(want.is_new));
                end
                if (out_data.table_full !== want.table_full) begin
                    report_mismatch("table_full", int'(out_data.table_full),
                                    int'(want.table_full));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when no handshake happens for too long.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("status: fail");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------
    initial begin
        logic [8*vtdi_pkg::WORD_W-1:0] mesh_pool[$];
        logic [8*vtdi_pkg::WORD_W-1:0] w;
        logic                          first;
        logic                          filled_late;
        int                            mesh_count;
        int                            len;
        int                            pick;

        filled_late = 1'b0;
        mesh_count  = 0;

        // Directed: field extremes, matches, misses by a single bit, clears.
        queue_corner(1'b0, '0);                          // empty table after reset
        queue_corner(1'b0, '1);
        queue_corner(1'b0, '0);                          // match entry 0
        queue_corner(1'b0, '1);                          // match entry 1
        queue_corner(1'b0, 256'h1);                      // differs in tex_v bit 0 only
        queue_corner(1'b0, {1'b1, 255'b0});              // differs in pos_x bit 31 only
        queue_corner(1'b0, {8{32'h8000_0000}});          // negative zero is its own tuple
        queue_corner(1'b0, {8{32'h7f80_0000}});
        queue_corner(1'b0, {8{32'h7fc0_0000}});
        queue_corner(1'b0, {8{32'h7fc0_0000}});          // NaN bits still match exactly
        queue_corner(1'b0, {8{32'haaaa_aaaa}});
        queue_corner(1'b0, {8{32'h5555_5555}});
        queue_corner(1'b0, {{3{32'h3f80_0000}}, 160'b0});
        queue_corner(1'b0, {{3{32'h3f80_0000}}, 32'h3f80_0000, 128'b0}); // same position
        queue_corner(1'b0, 256'h1);                      // match an older entry
        queue_corner(1'b1, '1);                          // clear, then store at 0
        queue_corner(1'b0, '0);                          // old entries are gone
        queue_corner(1'b0, '1);
        queue_corner(1'b1, '1);                          // clear and re-store same tuple
        queue_corner(1'b1, '0);                          // back-to-back clears
        queue_corner(1'b0, {8{32'haaaa_aaaa}});

        // Random meshes: mostly short ones that reuse a small pool of corners,
        // plus two that fill every entry and then probe the full table.
        while (corners_queued < CORNER_GOAL) begin
            mesh_pool.delete();
            if (mesh_count == 2 || (!filled_late && corners_queued >= 1400)) begin
                if (mesh_count != 2) begin
                    filled_late = 1'b1;
                end
                for (int k = 0; k < vtdi_pkg::TABLE_DEPTH; k++) begin
                    w = random_words();
                    mesh_pool.push_back(w);
                    queue_corner(k == 0, w);
                end
                for (int k = 0; k < 24; k++) begin
                    case (k % 4)
                        0: w = random_words();
                        1: w = mesh_pool[$urandom_range(vtdi_pkg::TABLE_DEPTH - 1)];
                        2: w = mesh_pool[(k % 8 == 2) ? vtdi_pkg::TABLE_DEPTH - 1 : 0];
                        default: w = mesh_pool[$urandom_range(vtdi_pkg::TABLE_DEPTH - 1)]
                                     ^ (256'b1 << $urandom_range(255));
                    endcase
                    queue_corner(1'b0, w);
                end
            end else begin
                len = $urandom_range(12, 1);
                for (int k = 0; k < len; k++) begin
                    mesh_pool.push_back(random_words());
                end
                len = $urandom_range(40, 1);
                for (int k = 0; k < len; k++) begin
                    pick = $urandom_range(99);
                    if (pick < 70) begin
                        w = mesh_pool[$urandom_range(mesh_pool.size() - 1)];
                    end else if (pick < 85) begin
                        w = mesh_pool[$urandom_range(mesh_pool.size() - 1)]
                            ^ (256'b1 << $urandom_range(255));
                    end else begin
                        w = random_words();
                    end
                    // Drop the opening flag now and then, and raise a stray one.
                    if (k == 0) begin
                        first = ($urandom_range(9) != 0);
                    end else begin
                        first = ($urandom_range(99) < 3);
                    end
                    queue_corner(first, w);
                end
            end
            mesh_count++;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: all requests taken, all results back, then a full scan more.
        while (pending_corners.size() != 0 || in_valid) @(negedge clk);
        while (owed_results.size() != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
